// ===== sv/i2cm_pkg.sv =====
package i2cm_pkg;

  // Request codes carried in req_type
  localparam logic [1:0] REQ_WRITE = 2'd0;
  localparam logic [1:0] REQ_READ  = 2'd1;
  localparam logic [1:0] REQ_STOP  = 2'd2;

  localparam logic [3:0] BITS_PER_BYTE = 4'd8;
  localparam logic [15:0] HALF_PERIOD_RESET = 16'd250;

  typedef enum logic [3:0] {
    PH_IDLE   = 4'd0,
    PH_RS_D1  = 4'd1,
    PH_RS_W   = 4'd2,
    PH_RS_D2  = 4'd3,
    PH_ST_CHK = 4'd4,
    PH_ST_D   = 4'd5,
    PH_B_D1   = 4'd6,
    PH_B_W    = 4'd7,
    PH_B_D2   = 4'd8,
    PH_SP_D1  = 4'd9,
    PH_SP_W   = 4'd10,
    PH_SP_D2  = 4'd11,
    PH_SP_CHK = 4'd12,
    PH_SP_D3  = 4'd13
  } phase_e;

  typedef struct packed {
    logic       cmd_valid;
    logic [1:0] req_type;
    logic [7:0] tx_byte;
    logic       with_start;
    logic       with_stop;
    logic       ack_to_send;
    logic       scl_level;
    logic       sda_level;
  } in_item_t;

  typedef struct packed {
    logic       scl_drive_low;
    logic       sda_drive_low;
    logic       busy_res;
    logic       done_res;
    logic [7:0] rx_byte;
    logic       nack_seen;
    logic       arb_lost;
    logic       bus_started;
  } out_item_t;

  typedef struct packed {
    phase_e     phase;
    logic [3:0] bit_idx;
    logic [7:0] shreg;
    logic       started;
    logic       scl_low;
    logic       sda_low;
    logic [1:0] cmd_type;
    logic       cmd_stop;
    logic       ack;
    logic [7:0] rx;
    logic       nack;
    logic       arb;
  } state_t;

  function automatic logic master_drives(logic [1:0] t, logic [3:0] b);
    return (t == REQ_WRITE) ? (b < BITS_PER_BYTE) : (b == BITS_PER_BYTE);
  endfunction

  function automatic logic drive_value(logic [1:0] t, logic [7:0] sh, logic ack);
    return (t == REQ_WRITE) ? sh[7] : ack;
  endfunction

endpackage

// ===== sv/i2cm_step.sv =====
module i2cm_step #(
  parameter int DelayW = 16
) (
  input  i2cm_pkg::state_t   st_i,
  input  logic [DelayW-1:0]  dcnt_i,
  input  logic [DelayW-1:0]  lim_i,
  input  i2cm_pkg::in_item_t item_i,
  output i2cm_pkg::state_t   st_o,
  output logic [DelayW-1:0]  dcnt_o,
  output logic               done_o
);
  import i2cm_pkg::*;

  logic              over;
  logic [DelayW-1:0] dnext;

  assign over  = (dcnt_i >= lim_i);
  assign dnext = over ? '0 : DelayW'(dcnt_i + 1'b1);

  always_comb begin
    st_o   = st_i;
    dcnt_o = dcnt_i;
    done_o = 1'b0;
    if (st_i.phase == PH_IDLE) begin
      if (item_i.cmd_valid && (item_i.req_type inside {REQ_WRITE, REQ_READ, REQ_STOP})) begin
        st_o.arb      = 1'b0;
        st_o.cmd_type = item_i.req_type;
        st_o.cmd_stop = item_i.with_stop;
        st_o.shreg    = (item_i.req_type == REQ_WRITE) ? item_i.tx_byte : 8'h00;
        st_o.ack      = (item_i.req_type == REQ_READ) ? item_i.ack_to_send : 1'b0;
        st_o.bit_idx  = '0;
        dcnt_o        = '0;
        if (item_i.req_type == REQ_STOP) begin
          st_o.sda_low = 1'b1;
          st_o.phase   = PH_SP_D1;
        end else if (item_i.req_type == REQ_WRITE && item_i.with_start) begin
          if (st_i.started) begin
            // repeated start: release SDA, then bring SCL high
            st_o.sda_low = 1'b0;
            st_o.phase   = PH_RS_D1;
          end else begin
            st_o.phase = PH_ST_CHK;
          end
        end else begin
          st_o.sda_low = master_drives(st_o.cmd_type, st_o.bit_idx) ?
                         ~drive_value(st_o.cmd_type, st_o.shreg, st_o.ack) : 1'b0;
          st_o.phase   = PH_B_D1;
        end
      end
    end else begin
      case (st_i.phase)
        PH_RS_D1: begin
          dcnt_o = dnext;
          if (over) begin
            st_o.scl_low = 1'b0;
            st_o.phase   = PH_RS_W;
          end
        end
        PH_RS_W: begin
          if (item_i.scl_level) begin
            st_o.phase = PH_RS_D2;
            dcnt_o     = '0;
          end
        end
        PH_RS_D2: begin
          dcnt_o = dnext;
          if (over) st_o.phase = PH_ST_CHK;
        end
        PH_ST_CHK: begin
          dcnt_o = '0;
          if (!item_i.sda_level) begin
            st_o.scl_low = 1'b0;
            st_o.sda_low = 1'b0;
            st_o.started = 1'b0;
            st_o.arb     = 1'b1;
            done_o       = 1'b1;
            st_o.phase   = PH_IDLE;
          end else begin
            st_o.sda_low = 1'b1;
            st_o.phase   = PH_ST_D;
          end
        end
        PH_ST_D: begin
          dcnt_o = dnext;
          if (over) begin
            st_o.scl_low = 1'b1;
            st_o.started = 1'b1;
            st_o.sda_low = master_drives(st_o.cmd_type, st_o.bit_idx) ?
                           ~drive_value(st_o.cmd_type, st_o.shreg, st_o.ack) : 1'b0;
            st_o.phase   = PH_B_D1;
          end
        end
        PH_B_D1: begin
          dcnt_o = dnext;
          if (over) begin
            st_o.scl_low = 1'b0;
            st_o.phase   = PH_B_W;
          end
        end
        PH_B_W: begin
          // wait out clock stretching, then sample
          if (item_i.scl_level) begin
            dcnt_o     = '0;
            st_o.phase = PH_B_D2;
            if (master_drives(st_i.cmd_type, st_i.bit_idx)) begin
              if (drive_value(st_i.cmd_type, st_i.shreg, st_i.ack) && !item_i.sda_level) begin
                st_o.scl_low = 1'b0;
                st_o.sda_low = 1'b0;
                st_o.started = 1'b0;
                st_o.arb     = 1'b1;
                done_o       = 1'b1;
                st_o.phase   = PH_IDLE;
              end
            end else if (st_i.cmd_type == REQ_WRITE) begin
              st_o.ack = item_i.sda_level;
            end else begin
              st_o.shreg = {st_i.shreg[6:0], item_i.sda_level};
            end
          end
        end
        PH_B_D2: begin
          dcnt_o = dnext;
          if (over) begin
            st_o.scl_low = 1'b1;
            if (st_i.cmd_type == REQ_WRITE && st_i.bit_idx < BITS_PER_BYTE) begin
              st_o.shreg = {st_i.shreg[6:0], 1'b0};
            end
            st_o.bit_idx = st_i.bit_idx + 4'd1;
            if (st_o.bit_idx <= BITS_PER_BYTE) begin
              st_o.sda_low = master_drives(st_o.cmd_type, st_o.bit_idx) ?
                             ~drive_value(st_o.cmd_type, st_o.shreg, st_o.ack) : 1'b0;
              st_o.phase   = PH_B_D1;
            end else begin
              if (st_i.cmd_type == REQ_WRITE) st_o.nack = st_i.ack;
              else st_o.rx = st_o.shreg;
              if (st_i.cmd_stop) begin
                st_o.sda_low = 1'b1;
                st_o.phase   = PH_SP_D1;
              end else begin
                done_o     = 1'b1;
                st_o.phase = PH_IDLE;
              end
            end
          end
        end
        PH_SP_D1: begin
          dcnt_o = dnext;
          if (over) begin
            st_o.scl_low = 1'b0;
            st_o.phase   = PH_SP_W;
          end
        end
        PH_SP_W: begin
          if (item_i.scl_level) begin
            st_o.phase = PH_SP_D2;
            dcnt_o     = '0;
          end
        end
        PH_SP_D2: begin
          dcnt_o = dnext;
          if (over) begin
            st_o.sda_low = 1'b0;
            st_o.phase   = PH_SP_CHK;
          end
        end
        PH_SP_CHK: begin
          dcnt_o = '0;
          if (!item_i.sda_level) begin
            st_o.scl_low = 1'b0;
            st_o.sda_low = 1'b0;
            st_o.started = 1'b0;
            st_o.arb     = 1'b1;
            done_o       = 1'b1;
            st_o.phase   = PH_IDLE;
          end else begin
            st_o.phase = PH_SP_D3;
          end
        end
        PH_SP_D3: begin
          dcnt_o = dnext;
          if (over) begin
            st_o.started = 1'b0;
            done_o       = 1'b1;
            st_o.phase   = PH_IDLE;
          end
        end
        default: begin
          st_o.phase = PH_IDLE;
          dcnt_o     = '0;
        end
      endcase
    end
  end

endmodule

// ===== sv/i2c_master_byte_engine.sv =====
// Channel  Direction  Word           Handshake
// in       input      in_item_t      in_valid_i / in_ready_o
// out      output     out_item_t     out_valid_o / out_ready_i
// cfg      input      16-bit period  cfg_valid_i / cfg_ready_o (always ready)
//
// One word per clock while the output drains: each accepted tick word updates the bus
// state in the same cycle and its status word lands in the output register, so
// the sustained rate is one word per cycle, set by the state/result register pair.
// Reset clears the bus state and loads a half period of 250 ticks.
// A stalled output holds its word; input is taken again once it drains.
module i2c_master_byte_engine #(
  parameter int DELAY_WIDTH = 16
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  i2cm_pkg::in_item_t  in_data_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output i2cm_pkg::out_item_t out_data_o,
  input  logic                cfg_valid_i,
  output logic                cfg_ready_o,
  input  logic [15:0]         cfg_data_i
);
  import i2cm_pkg::*;

  logic [15:0]            half_q;
  logic [DELAY_WIDTH-1:0] lim;
  state_t                 st_q, st_d;
  logic [DELAY_WIDTH-1:0] dcnt_q, dcnt_d;
  logic                   done_d;
  logic                   out_valid_q;
  out_item_t              out_q, out_d;
  logic                   in_acc;

  assign cfg_ready_o = 1'b1;
  assign in_ready_o  = !out_valid_q || out_ready_i;
  assign in_acc      = in_valid_i && in_ready_o;

  // period is taken modulo the counter width
  if (DELAY_WIDTH >= 16) begin : g_lim_wide
    assign lim = DELAY_WIDTH'(half_q);
  end else begin : g_lim_narrow
    assign lim = half_q[DELAY_WIDTH-1:0];
  end

  i2cm_step #(.DelayW(DELAY_WIDTH)) u_step (
    .st_i   (st_q),
    .dcnt_i (dcnt_q),
    .lim_i  (lim),
    .item_i (in_data_i),
    .st_o   (st_d),
    .dcnt_o (dcnt_d),
    .done_o (done_d)
  );

  always_comb begin
    out_d.scl_drive_low = st_d.scl_low;
    out_d.sda_drive_low = st_d.sda_low;
    out_d.busy_res      = (st_d.phase != PH_IDLE);
    out_d.done_res      = done_d;
    out_d.rx_byte       = st_d.rx;
    out_d.nack_seen     = st_d.nack;
    out_d.arb_lost      = st_d.arb;
    out_d.bus_started   = st_d.started;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      half_q <= HALF_PERIOD_RESET;
    end else if (cfg_valid_i && cfg_ready_o) begin
      half_q <= cfg_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q   <= '{phase: PH_IDLE, default: '0};
      dcnt_q <= '0;
    end else if (in_acc) begin
      st_q   <= st_d;
      dcnt_q <= dcnt_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (in_acc) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  // hold the result word while stalled
  always_ff @(posedge clk_i) begin
    if (in_acc) out_q <= out_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  a_done_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.done_res |-> !out_data_o.busy_res)
    else $error("done reported while still busy");

  a_arb_release: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.arb_lost |->
      !out_data_o.scl_drive_low && !out_data_o.sda_drive_low && !out_data_o.bus_started)
    else $error("lines or start flag held after lost arbitration");

  a_idle_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    st_q.phase == PH_IDLE |-> dcnt_q == '0)
    else $error("delay counter running while idle");

  a_acc_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |=> out_valid_o)
    else $error("accepted tick produced no result word");

endmodule
